// File: sv/fix_tile_reorder_defines.svh
// assertion macros used by the checker file
`ifndef FIX_TILE_REORDER_DEFINES_SVH
`define FIX_TILE_REORDER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FTR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ftr check failed");

// next-cycle implication, sampled on clk, off during reset
`define FTR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ftr check failed");

`endif

// File: sv/ftr_pkg.sv
package ftr_pkg;

	localparam int TILE_BYTES = 32;
	localparam int IDX_W      = 5;
	localparam int BYTE_W     = 8;
	localparam int TILE_NUM_W = 12;
	localparam int CFG_W      = 12;
	localparam int CFG_IDX_W  = 1;

	// register indexes of the config port
	localparam logic [CFG_IDX_W-1:0] REG_START_TILE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWAP_PAIRS = 1'd1;

	// last byte slot of a tile
	localparam logic [IDX_W-1:0] FILL_LAST = IDX_W'(TILE_BYTES - 1);

	// lane group flip: groups 16,24,0,8 go out in that order
	localparam logic [1:0] LANE_FLIP = 2'b10;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} ftr_state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              is_final;
	} ftr_in_t;

	typedef struct packed {
		logic [BYTE_W-1:0]     out_byte;
		logic [BYTE_W-1:0]     tile_usage;
		logic [TILE_NUM_W-1:0] tile_number;
		logic                  last;
	} ftr_out_t;

	typedef struct packed {
		logic              shift;
		logic              load;
		logic [BYTE_W-1:0] data;
	} ftr_cell_ctrl_t;

endpackage

// File: sv/ftr_stream_if.sv
interface ftr_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: sv/ftr_cell.sv
module ftr_cell import ftr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ftr_cell_ctrl_t      ctrl,
	input  logic [BYTE_W-1:0]   next_data,
	output logic [BYTE_W-1:0]   data_q
);

	// shift toward the output end while draining, else take a loaded byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (ctrl.shift) begin
			data_q <= next_data;
		end else if (ctrl.load) begin
			data_q <= ctrl.data;
		end
	end

endmodule

// File: sv/fix_tile_reorder.sv
// fix_tile_reorder: gathers 32-byte 8x8 4bpp tiles from a byte stream and
// sends each tile out reordered, per column c: bytes c+16, c+24, c, c+8.
// din  (sink)  : data_byte, is_final; one byte per transfer.
// dout (source): out_byte, tile_usage, tile_number, last; 32 transfers
//                per tile, last set on the 32nd.
// cfg_we/cfg_index/cfg_wdata: index 0 start_tile (reloads the tile
// counter at once), index 1 swap_pairs. Write only while the block idles.
// Each incoming byte is written straight into its output slot of a row of
// 32 byte cells, so the tile is already in output order when complete.
// While filling, din stays ready. The 32nd byte (or an is_final byte)
// turns the row into a shift chain: the first result shows in the next
// cycle and the row moves one cell per output transfer, shifting in
// zeros so it is clear for the next tile. din is not ready while the
// row drains, so the next tile's bytes wait until its last byte is sent.
// A stalled receiver simply holds the chain and the result in place.
// Reset clears the cells, the fill count, the tile counter and the config registers, not the latched tile header.
module fix_tile_reorder import ftr_pkg::*; #(
	parameter int TILE_TABLE_ENTRIES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	ftr_stream_if.sink           din,
	ftr_stream_if.source         dout
);

	localparam int CW        = $clog2(TILE_TABLE_ENTRIES);
	localparam int MOD_STEPS = 8;
	localparam logic [CW-1:0] LAST_TILE = CW'(TILE_TABLE_ENTRIES - 1);

	ftr_state_t         state_q, state_d;
	logic [IDX_W-1:0]   fill_q;
	logic [IDX_W-1:0]   drain_q;
	logic               swap_q;
	logic [CW-1:0]      start_red_q;
	logic [CW-1:0]      counter_q;
	logic [CW-1:0]      number_q;
	logic [BYTE_W-1:0]  usage_q;

	logic               in_acc, out_acc, trigger;
	logic [IDX_W-1:0]   pos, slot;
	logic [CFG_W-1:0]   red_x;
	logic [BYTE_W-1:0]  usage_d;

	ftr_cell_ctrl_t     ctrl   [TILE_BYTES];
	logic [BYTE_W-1:0]  cell_q [TILE_BYTES];

	assign in_acc  = din.valid && din.ready;
	assign out_acc = dout.valid && dout.ready;
	assign trigger = in_acc && (fill_q == FILL_LAST || din.payload.is_final);

	// byte position in the tile, then its slot in output order
	assign pos  = fill_q ^ {{(IDX_W-1){1'b0}}, swap_q};
	assign slot = {pos[2:0], pos[4:3] ^ LANE_FLIP};

	// start tile modulo table size by binary restoring steps
	always_comb begin
		red_x = cfg_wdata;
		for (int i = MOD_STEPS - 1; i >= 0; i--) begin
			if (32'(red_x) >= (32'(TILE_TABLE_ENTRIES) << i)) begin
				red_x = red_x - CFG_W'(32'(TILE_TABLE_ENTRIES) << i);
			end
		end
	end

	// cell row: load by slot while filling, shift on output transfer
	for (genvar g = 0; g < TILE_BYTES; g++) begin : g_cell
		logic [BYTE_W-1:0] next_data;

		assign ctrl[g].shift = out_acc;
		assign ctrl[g].load  = in_acc && (slot == IDX_W'(g));
		assign ctrl[g].data  = din.payload.data_byte;

		if (g == TILE_BYTES - 1) begin : g_tail
			assign next_data = '0;
		end else begin : g_link
			assign next_data = cell_q[g+1];
		end

		ftr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl[g]),
			.next_data (next_data),
			.data_q    (cell_q[g])
		);
	end

	// usage byte over the row as it stands after this write
	always_comb begin
		usage_d = '0;
		for (int i = 0; i < TILE_BYTES; i++) begin
			usage_d = usage_d | (ctrl[i].load ? ctrl[i].data : cell_q[i]);
		end
	end

	// config registers and tile counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q      <= 1'b0;
			start_red_q <= '0;
			counter_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_TILE: begin
					start_red_q <= CW'(red_x);
					counter_q   <= CW'(red_x);
				end
				REG_SWAP_PAIRS: begin
					swap_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end else if (trigger) begin
			if (din.payload.is_final) begin
				counter_q <= start_red_q;
			end else if (counter_q == LAST_TILE) begin
				counter_q <= '0;
			end else begin
				counter_q <= counter_q + CW'(1);
			end
		end
	end

	// tile header latched when the tile completes
	always_ff @(posedge clk) begin
		if (trigger) begin
			usage_q  <= usage_d;
			number_q <= counter_q;
		end
	end

	// fill and drain counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			drain_q <= '0;
		end else begin
			if (in_acc) begin
				fill_q <= trigger ? '0 : fill_q + IDX_W'(1);
			end
			if (out_acc) begin
				drain_q <= drain_q + IDX_W'(1);
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d    = state_q;
		din.ready  = 1'b0;
		dout.valid = 1'b0;
		unique case (state_q)
			ST_FILL: begin
				din.ready = 1'b1;
				if (trigger) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				dout.valid = 1'b1;
				if (out_acc && drain_q == FILL_LAST) begin
					state_d = ST_FILL;
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

	// result payload
	assign dout.payload.out_byte    = cell_q[0];
	assign dout.payload.tile_usage  = usage_q;
	assign dout.payload.tile_number = TILE_NUM_W'(number_q);
	assign dout.payload.last        = (drain_q == FILL_LAST);

endmodule

// File: sv/ftr_checker.sv
`include "fix_tile_reorder_defines.svh"

module ftr_checker import ftr_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [BYTE_W-1:0]     out_byte,
	input logic [BYTE_W-1:0]     tile_usage,
	input logic [TILE_NUM_W-1:0] tile_number,
	input logic                  out_last
);

	// a stalled result holds
	`FTR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last))

	// no byte taken while a tile drains
	`FTR_ASSERT_NOW(a_no_overlap, out_valid, !in_ready)

	// every byte of a tile is covered by its usage byte
	`FTR_ASSERT_NOW(a_usage_cover, out_valid, (out_byte & ~tile_usage) == '0)

	// the tile keeps going until its last byte
	`FTR_ASSERT_NEXT(a_tile_cont, out_valid && out_ready && !out_last, out_valid && $stable(tile_number) && $stable(tile_usage))

	// after the last byte the block goes back to filling
	`FTR_ASSERT_NEXT(a_tile_end, out_valid && out_ready && out_last, !out_valid && in_ready)

endmodule

bind fix_tile_reorder ftr_checker u_ftr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (din.valid),
	.in_ready    (din.ready),
	.out_valid   (dout.valid),
	.out_ready   (dout.ready),
	.out_byte    (dout.payload.out_byte),
	.tile_usage  (dout.payload.tile_usage),
	.tile_number (dout.payload.tile_number),
	.out_last    (dout.payload.last)
);

// File: dv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ftr_pkg::*;

	localparam int TABLE_SIZE  = 4096;
	localparam int IDLE_PCT    = 29;
	localparam int HOLD_CYCLES = 120;
	localparam int STALL_LIMIT = 2000;
	localparam int RAND_ITEMS  = 180;
	localparam int DRAIN_WAIT  = 40;

	// source offsets of the four output lanes within one column
	localparam int LANE_OFS [4] = '{16, 24, 0, 8};

	typedef enum logic {
		ROW_BYTE,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_W-1:0]      value;
		logic                  fin;
		bit                    chk;
		logic [BYTE_W-1:0]     usage;
		logic [TILE_NUM_W-1:0] tile_no;
	} dir_row_t;

	// directed rows: byte rows carry data in value[7:0], cfg rows a register write
	dir_row_t dir_rows [14] = '{
		// single byte tile, all ones
		'{ROW_BYTE, REG_START_TILE, 12'h0FF, 1'b1, 1'b1, 8'hFF, 12'h000},
		// single byte tile, all zeros
		'{ROW_BYTE, REG_START_TILE, 12'h000, 1'b1, 1'b1, 8'h00, 12'h000},
		// short partial tile, padded with zeros
		'{ROW_BYTE, REG_START_TILE, 12'h001, 1'b0, 1'b0, 8'h00, 12'h000},
		'{ROW_BYTE, REG_START_TILE, 12'h080, 1'b0, 1'b0, 8'h00, 12'h000},
		'{ROW_BYTE, REG_START_TILE, 12'h05A, 1'b1, 1'b1, 8'hDB, 12'h000},
		// top tile number, pair swap on
		'{ROW_CFG,  REG_START_TILE, 12'hFFF, 1'b0, 1'b0, 8'h00, 12'h000},
		'{ROW_CFG,  REG_SWAP_PAIRS, 12'h001, 1'b0, 1'b0, 8'h00, 12'h000},
		// swap with odd length: lone byte lands on the odd slot
		'{ROW_BYTE, REG_START_TILE, 12'h03C, 1'b1, 1'b1, 8'h3C, 12'hFFF},
		'{ROW_BYTE, REG_START_TILE, 12'h012, 1'b0, 1'b0, 8'h00, 12'h000},
		'{ROW_BYTE, REG_START_TILE, 12'h034, 1'b1, 1'b1, 8'h36, 12'hFFF},
		// swap off, upper data bits set
		'{ROW_CFG,  REG_SWAP_PAIRS, 12'hFFE, 1'b0, 1'b0, 8'h00, 12'h000},
		// start tile rewritten while a byte is gathered
		'{ROW_BYTE, REG_START_TILE, 12'h0A5, 1'b0, 1'b0, 8'h00, 12'h000},
		'{ROW_CFG,  REG_START_TILE, 12'h007, 1'b0, 1'b0, 8'h00, 12'h000},
		'{ROW_BYTE, REG_START_TILE, 12'h05A, 1'b1, 1'b1, 8'hFF, 12'h007}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	ftr_stream_if #(.T(ftr_in_t))  din_if ();
	ftr_stream_if #(.T(ftr_out_t)) dout_if ();

	fix_tile_reorder #(.TILE_TABLE_ENTRIES(TABLE_SIZE)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.din       (din_if),
		.dout      (dout_if)
	);

	// mirror of the tile gather state and registers
	logic [BYTE_W-1:0]     tile_img [TILE_BYTES];
	logic [IDX_W-1:0]      fill_cnt;
	logic [TILE_NUM_W-1:0] tile_ctr;
	logic [TILE_NUM_W-1:0] start_tile;
	logic                  swap_on;

	// reordered bytes still owed by the block, oldest first
	ftr_out_t tile_out_q [$];

	int err_cnt;
	int items_sent;
	bit no_idle;
	bit hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(string what, int got, int want);
		$display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
		err_cnt++;
	endtask

	// store one byte, emit the reordered tile when it closes
	task automatic gather_byte(logic [BYTE_W-1:0] b, logic fin);
		logic [IDX_W-1:0]  pos;
		logic [BYTE_W-1:0] usage;
		ftr_out_t          r;
		int                n;
		pos = fill_cnt;
		if (swap_on) begin
			pos[0] = ~pos[0];
		end
		tile_img[pos] = b;
		if (fill_cnt < FILL_LAST && !fin) begin
			fill_cnt++;
			return;
		end
		usage = '0;
		for (int i = 0; i < TILE_BYTES; i++) begin
			usage |= tile_img[i];
		end
		n = 0;
		for (int c = 0; c < 8; c++) begin
			for (int k = 0; k < 4; k++) begin
				r.out_byte    = tile_img[c + LANE_OFS[k]];
				r.tile_usage  = usage;
				r.tile_number = tile_ctr;
				r.last        = (n == TILE_BYTES - 1);
				tile_out_q.push_back(r);
				n++;
			end
		end
		for (int i = 0; i < TILE_BYTES; i++) begin
			tile_img[i] = '0;
		end
		fill_cnt = '0;
		if (fin) begin
			tile_ctr = start_tile;
		end else begin
			tile_ctr = TILE_NUM_W'((tile_ctr + 1) % TABLE_SIZE);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == REG_START_TILE) begin
			start_tile = TILE_NUM_W'(val % TABLE_SIZE);
			tile_ctr   = start_tile;
		end else if (idx == REG_SWAP_PAIRS) begin
			swap_on = val[0];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// offer one byte, with random gaps, until the block takes it
	task automatic put_byte(logic [BYTE_W-1:0] b, logic fin);
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			din_if.valid <= 1'b0;
			@(negedge clk);
		end
		din_if.valid   <= 1'b1;
		din_if.payload <= '{data_byte: b, is_final: fin};
		do @(posedge clk); while (!din_if.ready);
		gather_byte(b, fin);
		items_sent++;
	endtask

	// stop offering and wait for every owed result
	task automatic wait_drained();
		@(negedge clk);
		din_if.valid <= 1'b0;
		while (tile_out_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [BYTE_W-1:0] rand_byte();
		case ($urandom_range(0, 7))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hFF;
			end
			default: begin
				return BYTE_W'($urandom_range(0, 255));
			end
		endcase
	endfunction

	task automatic send_transfer(int len, bit fin_at_end);
		for (int i = 0; i < len; i++) begin
			put_byte(rand_byte(), fin_at_end && (i == len - 1));
		end
	endtask

	// receiver: random stalls, one long hold-off on request
	initial begin
		dout_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				dout_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				dout_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// compare each output transfer with the oldest owed result
	always @(posedge clk) begin : chk_out
		ftr_out_t want;
		if (arst_n && dout_if.valid && dout_if.ready) begin
			if (tile_out_q.size() == 0) begin
				report("out_byte, none owed", dout_if.payload.out_byte, 0);
			end else begin
				want = tile_out_q.pop_front();
				if (dout_if.payload.out_byte !== want.out_byte) begin
					report("out_byte", dout_if.payload.out_byte, want.out_byte);
				end
				if (dout_if.payload.tile_usage !== want.tile_usage) begin
					report("tile_usage", dout_if.payload.tile_usage, want.tile_usage);
				end
				if (dout_if.payload.tile_number !== want.tile_number) begin
					report("tile_number", dout_if.payload.tile_number, want.tile_number);
				end
				if (dout_if.payload.last !== want.last) begin
					report("last", dout_if.payload.last, want.last);
				end
			end
		end
	end

	// watchdog on cycles with no transfer and no register write
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) || cfg_we) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin : main
		int ph;
		int len;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_START_TILE;
		cfg_wdata      = '0;
		din_if.valid   = 1'b0;
		din_if.payload = '0;
		for (int i = 0; i < TILE_BYTES; i++) begin
			tile_img[i] = '0;
		end
		fill_cnt   = '0;
		start_tile = '0;
		tile_ctr   = '0;
		swap_on    = 1'b0;
		err_cnt    = 0;
		items_sent = 0;
		no_idle    = 1'b0;
		hold_req   = 1'b0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows; typed usage and tile number replace the mirror's
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_drained();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
			end else begin
				put_byte(dir_rows[i].value[BYTE_W-1:0], dir_rows[i].fin);
				if (dir_rows[i].chk) begin
					for (int j = tile_out_q.size() - TILE_BYTES; j < tile_out_q.size(); j++) begin
						tile_out_q[j].tile_usage  = dir_rows[i].usage;
						tile_out_q[j].tile_number = dir_rows[i].tile_no;
					end
				end
			end
		end

		// random phases, each under its own register setting
		items_sent = 0;
		ph = 0;
		while (items_sent < RAND_ITEMS || ph < 3) begin
			wait_drained();
			write_reg(REG_START_TILE, (ph == 0) ? 12'hFFF : (ph == 1) ? 12'h000 : 12'($urandom));
			write_reg(REG_SWAP_PAIRS, 12'($urandom));
			no_idle = (ph == 2);
			if (ph == 0) begin
				// counter wrap at the table end, output held off meanwhile
				hold_req = 1'b1;
				send_transfer(64, 1'b0);
				send_transfer($urandom_range(1, 31), 1'b1);
			end else if (ph == 2) begin
				// long stretch with no idling on either side
				send_transfer(2 * TILE_BYTES, 1'b1);
			end else begin
				repeat ($urandom_range(1, 2)) begin
					case ($urandom_range(0, 3))
						0: begin
							len = $urandom_range(1, 31);
						end
						1: begin
							len = TILE_BYTES;
						end
						2: begin
							len = 2 * TILE_BYTES;
						end
						default: begin
							len = $urandom_range(33, 70);
						end
					endcase
					send_transfer(len, $urandom_range(0, 4) != 0);
				end
			end
			ph++;
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_cnt == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

// File: fix_tile_reorder.f
+incdir+sv
sv/ftr_pkg.sv
sv/ftr_stream_if.sv
sv/ftr_cell.sv
sv/fix_tile_reorder.sv
sv/ftr_checker.sv
dv/tb_top.sv
